[design/windowed_variance_change_detector_defines.svh]
// Assertion helpers shared by the RTL files
`ifndef WINDOWED_VARIANCE_CHANGE_DETECTOR_DEFINES_SVH
`define WINDOWED_VARIANCE_CHANGE_DETECTOR_DEFINES_SVH

// Implication checked at every clock edge outside reset
`define WVCD_ASSERT_IMPL(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error(msg);

// Implication whose right side is checked in the cycle after the left side holds
`define WVCD_ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

[design/wvcd_pkg.sv]
`default_nettype none
package wvcd_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned MINP_W   = 7;
    localparam int unsigned WARM_W   = 8;
    localparam int unsigned VLIM_W   = 24;
    localparam int unsigned PLIM_W   = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PACKETS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LIMIT     = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_TOO_FEW = 2'd0,
        ST_WARMING = 2'd1,
        ST_QUIET   = 2'd2,
        ST_CHANGE  = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input transaction
        logic drop_full;  // evict oldest because the ring is full
        logic insert;     // write new sample, update sums
        logic rd_tail;    // read ring at the tail
        logic drop_aged;  // evict tail (data already read)
        logic scan_start; // begin extreme scan at tail
        logic scan_step;  // fold one read value, advance scan pointer
        logic mul_step;   // advance variance multiply sequencer
        logic clear;      // empty the window
        logic warm_inc;   // bump the warm-up counter
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic aged;       // tail read data is older than the window
        logic few;        // count <= min_packets
        logic warming;    // warm-up not finished
        logic scan_last;  // scan has consumed every entry
        logic mul_done;
        logic over;       // variance or peak exceeds its limit
    } dp_sts_t;

endpackage
`default_nettype wire

[design/wvcd_datapath.sv]
`default_nettype none
`include "windowed_variance_change_detector_defines.svh"
module wvcd_datapath #(
    parameter int unsigned WINDOW_DEPTH = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [wvcd_pkg::TIME_W-1:0]   in_time,
    input  wire logic [wvcd_pkg::VALUE_W-1:0]  in_db,
    input  wire logic [wvcd_pkg::TIME_W-1:0]   time_window,
    input  wire logic [wvcd_pkg::MINP_W-1:0]   min_packets,
    input  wire logic [wvcd_pkg::WARM_W-1:0]   warmup_count,
    input  wire logic [wvcd_pkg::VLIM_W-1:0]   variance_limit,
    input  wire logic [wvcd_pkg::PLIM_W-1:0]   peak_limit,
    input  wire wvcd_pkg::dp_cmd_t             cmd,
    output wvcd_pkg::dp_sts_t                  sts,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]  count
);
    localparam int unsigned PW = $clog2(WINDOW_DEPTH);
    localparam int unsigned CW = $clog2(WINDOW_DEPTH+1);
    localparam int unsigned VW = wvcd_pkg::VALUE_W;
    localparam int unsigned SW = VW + PW + 1;       // sum
    localparam int unsigned QW = 2*VW + PW;         // sum of squares (unsigned)
    localparam int unsigned NW = CW;
    // n*S2 and S^2 and the bound, all fit in this width
    localparam int unsigned PRW = QW + NW + 2;
    localparam int unsigned BW  = wvcd_pkg::VLIM_W + 8 + 2*NW;
    localparam int unsigned XW  = (PRW > BW) ? PRW : BW;

    logic [wvcd_pkg::TIME_W-1:0] time_ring [WINDOW_DEPTH];
    logic [VW-1:0]               value_ring [WINDOW_DEPTH];

    logic [wvcd_pkg::TIME_W-1:0] now_reg;
    logic signed [VW-1:0]        val_reg;
    logic [PW-1:0]               head_reg, tail_reg, scan_reg;
    logic [CW-1:0]               count_reg, left_reg;
    logic signed [SW-1:0]        sum_reg;
    logic [QW-1:0]               sq_reg;
    logic [wvcd_pkg::WARM_W-1:0] warm_reg;
    logic [wvcd_pkg::TIME_W-1:0] rd_time_reg;
    logic signed [VW-1:0]        rd_val_reg;
    logic signed [VW-1:0]        hi_reg, lo_reg;
    logic                        scan_valid_reg;

    // variance multiply sequencer
    logic [2:0]      mstep_reg;
    logic [XW-1:0]   nq_reg, ss_reg, bnd_reg;
    logic            mdone_reg;

    logic [PW-1:0] rd_addr;
    logic signed [2*VW-1:0] vsq, rsq;

    assign vsq = val_reg * val_reg;
    assign rsq = rd_val_reg * rd_val_reg;

    always_comb begin
        rd_addr = tail_reg;
        if (cmd.scan_start)     rd_addr = tail_reg;
        else if (cmd.scan_step) rd_addr = (scan_reg == PW'(WINDOW_DEPTH-1)) ? '0
                                          : scan_reg + PW'(1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            time_ring[head_reg]  <= now_reg;
            value_ring[head_reg] <= val_reg;
        end
        rd_time_reg <= time_ring[rd_addr];
        rd_val_reg  <= value_ring[rd_addr];
        if (cmd.load) begin
            now_reg <= in_time;
            val_reg <= in_db;
        end
    end

    function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
        inc_ptr = (p == PW'(WINDOW_DEPTH-1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            warm_reg  <= '0;
            scan_valid_reg <= 1'b0;
            mstep_reg <= '0;
            mdone_reg <= 1'b0;
        end else begin
            scan_valid_reg <= cmd.scan_start || cmd.scan_step;
            if (cmd.drop_full || cmd.drop_aged) begin
                sum_reg   <= sum_reg - SW'(rd_val_reg);
                sq_reg    <= sq_reg - QW'(unsigned'(rsq));
                count_reg <= count_reg - CW'(1);
                tail_reg  <= inc_ptr(tail_reg);
            end
            if (cmd.insert) begin
                sum_reg   <= sum_reg + SW'(val_reg);
                sq_reg    <= sq_reg + QW'(unsigned'(vsq));
                count_reg <= count_reg + CW'(1);
                head_reg  <= inc_ptr(head_reg);
            end
            if (cmd.warm_inc) warm_reg <= warm_reg + wvcd_pkg::WARM_W'(1);
            if (cmd.scan_start) begin
                scan_reg <= tail_reg;
                left_reg <= count_reg;
                hi_reg   <= 16'sh8000;
                lo_reg   <= 16'sh7fff;
                mstep_reg <= 3'd1;
                mdone_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                scan_reg <= rd_addr;
            end
            if (scan_valid_reg && left_reg != '0) begin
                if (rd_val_reg > hi_reg) hi_reg <= rd_val_reg;
                if (rd_val_reg < lo_reg) lo_reg <= rd_val_reg;
                left_reg <= left_reg - CW'(1);
            end
            if (cmd.mul_step && mstep_reg != '0) begin
                case (mstep_reg)
                    3'd1: begin
                        nq_reg  <= XW'(count_reg) * XW'(sq_reg);
                        ss_reg  <= XW'(unsigned'(sum_reg < 0 ? -sum_reg : sum_reg));
                        bnd_reg <= XW'(variance_limit) * XW'(count_reg);
                    end
                    3'd2: begin
                        ss_reg  <= XW'(ss_reg[SW-1:0]) * XW'(ss_reg[SW-1:0]);
                        bnd_reg <= (XW'(bnd_reg[wvcd_pkg::VLIM_W+CW-1:0])
                                    * XW'(count_reg - CW'(1))) << 8;
                    end
                    3'd3: begin
                        nq_reg    <= nq_reg - ss_reg;
                        mdone_reg <= 1'b1;
                    end
                    default: ;
                endcase
                mstep_reg <= (mstep_reg == 3'd3) ? 3'd0 : mstep_reg + 3'd1;
            end
            if (cmd.clear) begin
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
                sum_reg   <= '0;
                sq_reg    <= '0;
            end
        end
    end

    logic [VW:0] peak;
    assign peak = (VW+1)'(hi_reg) - (VW+1)'(lo_reg);

    always_comb begin
        sts.full      = count_reg == CW'(WINDOW_DEPTH);
        sts.empty     = count_reg == '0;
        sts.aged      = (now_reg - rd_time_reg) > time_window;
        sts.few       = CW'(0) + count_reg <= ((CW > wvcd_pkg::MINP_W) ? CW'(min_packets)
                        : CW'(min_packets)) || ({1'b0, min_packets} >= (wvcd_pkg::MINP_W+1)'(count_reg) && CW <= wvcd_pkg::MINP_W);
        sts.warming   = warm_reg < warmup_count;
        // every entry has been folded once the remaining count runs out
        sts.scan_last = left_reg == '0;
        sts.mul_done  = mdone_reg;
        sts.over      = (count_reg >= CW'(2) && nq_reg > bnd_reg)
                        || (peak > (VW+1)'(peak_limit));
    end
    assign count = count_reg;

    `WVCD_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= CW'(WINDOW_DEPTH), "window count overflow")
    `WVCD_ASSERT_NEXT(a_clear_empty, aclk, aresetn, cmd.clear,
        count_reg == '0, "clear left samples")
    `WVCD_ASSERT_IMPL(a_no_drop_empty, aclk, aresetn, cmd.drop_aged,
        count_reg != '0, "eviction from empty window")
endmodule
`default_nettype wire

[design/wvcd_ctrl.sv]
`default_nettype none
`include "windowed_variance_change_detector_defines.svh"
module wvcd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wvcd_pkg::status_t      status,
    output wvcd_pkg::dp_cmd_t      cmd,
    input  wire wvcd_pkg::dp_sts_t sts
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FULL   = 9'b000000010,
        S_FULLD  = 9'b000000100,
        S_INS    = 9'b000001000,
        S_RD     = 9'b000010000,
        S_AGE    = 9'b000100000,
        S_DEC    = 9'b001000000,
        S_SCAN   = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    wvcd_pkg::status_t status_reg, status_next;

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: if (in_valid) begin
                cmd.load   = 1'b1;
                state_next = S_FULL;
            end
            S_FULL: state_next = sts.full ? S_FULLD : S_INS; // tail read lands
            S_FULLD: begin
                cmd.drop_full = 1'b1;
                state_next    = S_INS;
            end
            S_INS: begin
                cmd.insert = 1'b1;
                state_next = S_RD;
            end
            S_RD: begin
                cmd.rd_tail = 1'b1;
                state_next  = S_AGE;
            end
            S_AGE: begin
                if (!sts.empty && sts.aged) begin
                    cmd.drop_aged = 1'b1;
                    state_next    = S_RD;
                end else begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (sts.few) begin
                    status_next = wvcd_pkg::ST_TOO_FEW;
                    state_next  = S_OUT;
                end else if (sts.warming) begin
                    cmd.warm_inc = 1'b1;
                    status_next  = wvcd_pkg::ST_WARMING;
                    state_next   = S_OUT;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.mul_step = 1'b1;
                if (sts.scan_last && sts.mul_done) begin
                    if (sts.over) begin
                        status_next = wvcd_pkg::ST_CHANGE;
                    end else begin
                        status_next = wvcd_pkg::ST_QUIET;
                    end
                    state_next = S_OUT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_OUT: if (out_ready) begin
                // empty the window only after the count has gone out
                if (status_reg == wvcd_pkg::ST_CHANGE) cmd.clear = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= wvcd_pkg::ST_TOO_FEW;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign status    = status_reg;

    `WVCD_ASSERT_IMPL(a_onehot, aclk, aresetn, 1'b1, $onehot(state_reg),
        "state not one-hot")
    `WVCD_ASSERT_NEXT(a_load_busy, aclk, aresetn, in_valid && in_ready,
        !in_ready, "accepted while busy")
    `WVCD_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_valid && !out_ready,
        out_valid && $stable(status), "result dropped")
endmodule
`default_nettype wire

[design/windowed_variance_change_detector.sv]
// Sliding time-window variance change detector. Each s_ transaction (timestamp,
// signed Q8.8 dB) is added to a ring of WINDOW_DEPTH samples, aged-out samples
// are evicted one at a time, each by a tail read followed by an age check, and
// one m_ transaction reports status and window count. When the ring is full the
// oldest sample is evicted before the insert. A full decision adds an extreme
// scan, which folds one ring read per cycle beside the three-step variance
// multiply sequence. The result is held through output stalls; the next item is
// accepted after the result is taken.
// No clearing pass is needed.
`default_nettype none
module windowed_variance_change_detector #(
    parameter int unsigned WINDOW_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // sample_time[31:0], sample_db[47:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // status[1:0], window_count[8:2], zero fill
    input  wire logic        cfg_we,
    input  wire logic [wvcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wvcd_pkg::CFG_DATA_W-1:0] cfg_data
);
    logic [31:0] time_window_reg;
    logic [6:0]  min_packets_reg;
    logic [7:0]  warmup_count_reg;
    logic [23:0] variance_limit_reg;
    logic [15:0] peak_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_window_reg    <= 32'd5000;
            min_packets_reg    <= 7'd2;
            warmup_count_reg   <= 8'd7;
            variance_limit_reg <= 24'd154;
            peak_limit_reg     <= 16'd256;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wvcd_pkg::CFG_TIME_WINDOW:    time_window_reg    <= cfg_data;
                wvcd_pkg::CFG_MIN_PACKETS:    min_packets_reg    <= cfg_data[6:0];
                wvcd_pkg::CFG_WARMUP_COUNT:   warmup_count_reg   <= cfg_data[7:0];
                wvcd_pkg::CFG_VARIANCE_LIMIT: variance_limit_reg <= cfg_data[23:0];
                wvcd_pkg::CFG_PEAK_LIMIT:     peak_limit_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    wvcd_pkg::dp_cmd_t cmd;
    wvcd_pkg::dp_sts_t sts;
    wvcd_pkg::status_t status;
    logic [$clog2(WINDOW_DEPTH+1)-1:0] count;

    wvcd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .status(status), .cmd(cmd), .sts(sts)
    );

    wvcd_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_time(s_tdata[31:0]), .in_db(s_tdata[47:32]),
        .time_window(time_window_reg), .min_packets(min_packets_reg),
        .warmup_count(warmup_count_reg), .variance_limit(variance_limit_reg),
        .peak_limit(peak_limit_reg), .cmd(cmd), .sts(sts), .count(count)
    );

    assign m_tdata = {7'd0, 7'(count), status};
endmodule
`default_nettype wire
